@@ rtl/jsu_pkg.sv @@
// ----------------------------------------------------------------------------
// jsu_pkg
// shared types, codes and helpers for the json string unescaper
// ----------------------------------------------------------------------------
package jsu_pkg;

    // parse state
    typedef enum logic [1:0] {
        MODE_AWAIT = 2'd0,
        MODE_STR   = 2'd1,
        MODE_ESC   = 2'd2,
        MODE_HEX   = 2'd3
    } mode_t;

    // result kinds
    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    // error codes
    typedef enum logic [2:0] {
        ERR_NO_QUOTE   = 3'd0,
        ERR_END_STR    = 3'd1,
        ERR_END_ESC    = 3'd2,
        ERR_END_HEX    = 3'd3,
        ERR_BAD_HEX    = 3'd4,
        ERR_BAD_ESC    = 3'd5,
        ERR_CTRL       = 3'd6,
        ERR_UNUSED     = 3'd7
    } err_t;

    localparam int unsigned MAX_RESULTS = 3;

    // ascii codes
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_N = 8'h6e;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_U = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // utf-8 boundaries and lead marks
    localparam logic [15:0] UTF_MAX1 = 16'h007f;
    localparam logic [15:0] UTF_MAX2 = 16'h07ff;
    localparam logic [7:0] UTF_LEAD2 = 8'hc0;
    localparam logic [7:0] UTF_LEAD3 = 8'he0;
    localparam logic [7:0] UTF_CONT = 8'h80;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        err_t       err;
        logic       last;
    } res_t;

    // up to three results produced by one text item
    typedef struct packed {
        logic [1:0]           count;
        res_t [MAX_RESULTS-1:0] slot;
    } group_t;

    function automatic res_t res_data(input logic [7:0] d);
        res_t r;
        r.kind = KIND_DATA;
        r.data = d;
        r.err  = ERR_NO_QUOTE;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic res_t res_done();
        res_t r;
        r.kind = KIND_DONE;
        r.data = 8'h00;
        r.err  = ERR_NO_QUOTE;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic res_t res_err(input err_t e);
        res_t r;
        r.kind = KIND_ERR;
        r.data = 8'h00;
        r.err  = e;
        r.last = 1'b0;
        return r;
    endfunction

    // {valid, nibble} of an ascii hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [7:0] t;
        t = 8'h00;
        if (b inside {[8'h30:8'h39]}) begin
            t = b - 8'h30;
            return {1'b1, t[3:0]};
        end
        if (b inside {[8'h41:8'h46]}) begin
            t = b - 8'h37;
            return {1'b1, t[3:0]};
        end
        if (b inside {[8'h61:8'h66]}) begin
            t = b - 8'h57;
            return {1'b1, t[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

@@ rtl/jsu_decode.sv @@
// ----------------------------------------------------------------------------
// jsu_decode
// parse state and per-byte decode into a group of up to three results
// ----------------------------------------------------------------------------
module jsu_decode
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  logic [7:0]      text_byte,
    input  logic            end_mark,
    output jsu_pkg::group_t grp
);
    import jsu_pkg::*;

    mode_t       mode_reg;
    mode_t       mode_next;
    logic [1:0]  hex_cnt_reg;
    logic [1:0]  hex_cnt_next;
    logic [15:0] hex_code_reg;
    logic [15:0] hex_code_next;
    logic [4:0]  hv;
    logic [15:0] code_full;

    assign hv        = hex_value(text_byte);
    assign code_full = {hex_code_reg[11:0], hv[3:0]};

    // next state
    always_comb
    begin
        mode_next     = mode_reg;
        hex_cnt_next  = hex_cnt_reg;
        hex_code_next = hex_code_reg;
        case (mode_reg)
            MODE_AWAIT:
            begin
                if (!end_mark && text_byte == CH_QUOTE)
                begin
                    mode_next = MODE_STR;
                end
            end
            MODE_STR:
            begin
                if (end_mark || text_byte == CH_QUOTE || text_byte < CH_SPACE)
                begin
                    mode_next = MODE_AWAIT;
                end
                else if (text_byte == CH_BSLASH)
                begin
                    mode_next = MODE_ESC;
                end
            end
            MODE_ESC:
            begin
                if (end_mark)
                begin
                    mode_next = MODE_AWAIT;
                end
                else if (text_byte == CH_U)
                begin
                    mode_next     = MODE_HEX;
                    hex_cnt_next  = 2'd0;
                    hex_code_next = 16'h0000;
                end
                else if (text_byte inside {CH_QUOTE, CH_BSLASH, CH_SLASH,
                                           CH_B, CH_F, CH_N, CH_R, CH_T})
                begin
                    mode_next = MODE_STR;
                end
                else
                begin
                    mode_next = MODE_AWAIT;
                end
            end
            MODE_HEX:
            begin
                if (end_mark || !hv[4])
                begin
                    mode_next     = MODE_AWAIT;
                    hex_cnt_next  = 2'd0;
                    hex_code_next = 16'h0000;
                end
                else if (hex_cnt_reg == 2'd3)
                begin
                    mode_next     = MODE_STR;
                    hex_cnt_next  = 2'd0;
                    hex_code_next = 16'h0000;
                end
                else
                begin
                    hex_cnt_next  = hex_cnt_reg + 2'd1;
                    hex_code_next = code_full;
                end
            end
            default:
            begin
                mode_next = MODE_AWAIT;
            end
        endcase
    end

    // results
    always_comb
    begin
        grp = '0;
        case (mode_reg)
            MODE_AWAIT:
            begin
                if (end_mark || text_byte != CH_QUOTE)
                begin
                    grp.count   = 2'd1;
                    grp.slot[0] = res_err(ERR_NO_QUOTE);
                end
            end
            MODE_STR:
            begin
                grp.count = 2'd1;
                if (end_mark)
                begin
                    grp.slot[0] = res_err(ERR_END_STR);
                end
                else if (text_byte == CH_QUOTE)
                begin
                    grp.slot[0] = res_done();
                end
                else if (text_byte == CH_BSLASH)
                begin
                    grp.count = 2'd0;
                end
                else if (text_byte < CH_SPACE)
                begin
                    grp.slot[0] = res_err(ERR_CTRL);
                end
                else
                begin
                    grp.slot[0] = res_data(text_byte);
                end
            end
            MODE_ESC:
            begin
                grp.count = 2'd1;
                if (end_mark)
                begin
                    grp.slot[0] = res_err(ERR_END_ESC);
                end
                else
                begin
                    case (text_byte)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: grp.slot[0] = res_data(text_byte);
                        CH_B:    grp.slot[0] = res_data(8'h08);
                        CH_F:    grp.slot[0] = res_data(8'h0c);
                        CH_N:    grp.slot[0] = res_data(8'h0a);
                        CH_R:    grp.slot[0] = res_data(8'h0d);
                        CH_T:    grp.slot[0] = res_data(8'h09);
                        CH_U:    grp.count = 2'd0;
                        default: grp.slot[0] = res_err(ERR_BAD_ESC);
                    endcase
                end
            end
            MODE_HEX:
            begin
                if (end_mark)
                begin
                    grp.count   = 2'd1;
                    grp.slot[0] = res_err(ERR_END_HEX);
                end
                else if (!hv[4])
                begin
                    grp.count   = 2'd1;
                    grp.slot[0] = res_err(ERR_BAD_HEX);
                end
                else if (hex_cnt_reg == 2'd3)
                begin
                    // utf-8 encode of the completed code
                    if (code_full <= UTF_MAX1)
                    begin
                        grp.count   = 2'd1;
                        grp.slot[0] = res_data(code_full[7:0]);
                    end
                    else if (code_full <= UTF_MAX2)
                    begin
                        grp.count   = 2'd2;
                        grp.slot[0] = res_data(UTF_LEAD2 | {3'b000, code_full[10:6]});
                        grp.slot[1] = res_data(UTF_CONT | {2'b00, code_full[5:0]});
                    end
                    else
                    begin
                        grp.count   = 2'd3;
                        grp.slot[0] = res_data(UTF_LEAD3 | {4'h0, code_full[15:12]});
                        grp.slot[1] = res_data(UTF_CONT | {2'b00, code_full[11:6]});
                        grp.slot[2] = res_data(UTF_CONT | {2'b00, code_full[5:0]});
                    end
                end
            end
            default:
            begin
                grp.count = 2'd0;
            end
        endcase
        case (grp.count)
            2'd1:    grp.slot[0].last = 1'b1;
            2'd2:    grp.slot[1].last = 1'b1;
            2'd3:    grp.slot[2].last = 1'b1;
            default: grp.slot[0].last = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_AWAIT;
            hex_cnt_reg  <= 2'd0;
            hex_code_reg <= 16'h0000;
        end
        else if (fire)
        begin
            mode_reg     <= mode_next;
            hex_cnt_reg  <= hex_cnt_next;
            hex_code_reg <= hex_code_next;
        end
    end

endmodule

@@ rtl/jsu_emit.sv @@
// ----------------------------------------------------------------------------
// jsu_emit
// result register holding one group and handing it out one transfer at a time
// ----------------------------------------------------------------------------
module jsu_emit
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  jsu_pkg::group_t grp,
    output logic            grp_ready,
    output logic            result_valid,
    input  logic            result_ready,
    output jsu_pkg::res_t   head
);
    import jsu_pkg::*;

    logic [1:0]             count_reg;
    logic [1:0]             count_next;
    res_t [MAX_RESULTS-1:0] slot_reg;
    res_t [MAX_RESULTS-1:0] slot_next;
    logic                   out_fire;

    assign result_valid = (count_reg != 2'd0);
    assign out_fire     = result_valid && result_ready;
    // free now, or the last held result leaves this cycle
    assign grp_ready    = (count_reg == 2'd0) || (count_reg == 2'd1 && result_ready);
    assign head         = slot_reg[0];

    always_comb
    begin
        count_next = count_reg;
        slot_next  = slot_reg;
        if (load)
        begin
            count_next = grp.count;
            slot_next  = grp.slot;
        end
        else if (out_fire)
        begin
            count_next = count_reg - 2'd1;
            slot_next  = {slot_reg[MAX_RESULTS-1], slot_reg[MAX_RESULTS-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

@@ rtl/json_string_unescape.sv @@
// ----------------------------------------------------------------------------
// json_string_unescape
// path: a text byte accepted into the input register is decoded into the result
// register, whose head drives the result port; one register stage on each side
// throughput: one text byte per cycle while the result register can take each group;
// a \u code of two or three utf-8 bytes holds the input while the result register drains
// reset: rst_n clears the parse state to awaiting an opening quote and empties
// both the input and the result registers
// ----------------------------------------------------------------------------
module json_string_unescape
(
    input  logic       clk,
    input  logic       rst_n,
    // text channel
    input  logic       text_valid,
    output logic       text_ready,
    input  logic [7:0] text_byte,
    input  logic       end_mark,
    // result channel
    output logic       result_valid,
    input  logic       result_ready,
    output logic [1:0] kind,
    output logic [7:0] out_byte,
    output logic [2:0] error_code,
    output logic       run_last
);
    import jsu_pkg::*;

    // input register
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;

    // decode handshake
    logic   grp_ready;
    logic   dec_fire;
    group_t grp;
    res_t   head;

    // a held byte is decoded once the result register can take its group
    assign dec_fire   = in_valid_reg && grp_ready;
    // the input register refills in the same cycle its byte moves on
    assign text_ready = !in_valid_reg || grp_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (text_valid && text_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (dec_fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (text_valid && text_ready)
        begin
            in_byte_reg <= text_byte;
            in_end_reg  <= end_mark;
        end
    end

    // parse state and per-byte decode
    jsu_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (dec_fire),
        .text_byte (in_byte_reg),
        .end_mark  (in_end_reg),
        .grp       (grp)
    );

    // result register, one transfer per result
    jsu_emit u_emit
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (dec_fire),
        .grp          (grp),
        .grp_ready    (grp_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .head         (head)
    );

    assign kind       = head.kind;
    assign out_byte   = head.data;
    assign error_code = head.err;
    assign run_last   = head.last;

endmodule
